### hw/rtl/szdd_pkg.sv
// Shared types, constants and the microcode program of the SZDD LZSS decompressor.
// Used by szdd_window, szdd_sequencer and szdd_lzss_decompressor; depends on nothing.
`timescale 1ns / 1ps

package szdd_pkg;

    // History window geometry
    localparam int WIN_AW = 12;
    localparam logic [WIN_AW-1:0] WIN_START = 12'hFF0;
    localparam logic [7:0] WIN_FILL = 8'h20;

    // Header layout
    localparam logic [3:0] HDR_MODE_IDX = 4'd8;
    localparam logic [3:0] HDR_LAST_SIG = 4'd7;
    localparam logic [3:0] HDR_LEN0_IDX = 4'd10;
    localparam logic [3:0] HDR_LEN1_IDX = 4'd11;
    localparam logic [3:0] HDR_LEN2_IDX = 4'd12;
    localparam logic [3:0] HDR_LEN3_IDX = 4'd13;
    localparam logic [3:0] HDR_BYTES = 4'd14;
    localparam logic [7:0] MODE_BYTE = 8'h41;

    // Result status codes
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_BAD_MODE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Match token decode
    localparam logic [4:0] MATCH_MIN = 5'd3;

    // Microcode store
    localparam int UPC_W = 5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HDR,
        OP_CTRL,
        OP_TOKEN,
        OP_LIT,
        OP_NEXT,
        OP_MHIGH,
        OP_MREAD,
        OP_MCOPY,
        OP_ERR
    } szdd_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_ERR,
        C_HDR_MORE,
        C_MATCH,
        C_DONE,
        C_LAST_FLAG,
        C_COPY_MORE
    } szdd_cond_t;

    typedef struct packed {
        logic             take;
        logic             emit;
        szdd_op_t         op;
        szdd_cond_t       cond;
        logic [UPC_W-1:0] target;
    } szdd_uword_t;

    // Datapath status seen by the sequencer's jump logic
    typedef struct packed {
        logic err;
        logic hdr_more;
        logic is_match;
        logic done;
        logic last_flag;
        logic copy_more;
    } szdd_flags_t;

    // Current control word plus whether the step executes this cycle
    typedef struct packed {
        szdd_uword_t uw;
        logic        go;
    } szdd_ctl_t;

    // Step addresses
    localparam logic [UPC_W-1:0] UA_HDR      = 5'd0;
    localparam logic [UPC_W-1:0] UA_HDR_ERR  = 5'd1;
    localparam logic [UPC_W-1:0] UA_HDR_MORE = 5'd2;
    localparam logic [UPC_W-1:0] UA_CTRL     = 5'd3;
    localparam logic [UPC_W-1:0] UA_TOKEN    = 5'd4;
    localparam logic [UPC_W-1:0] UA_KIND     = 5'd5;
    localparam logic [UPC_W-1:0] UA_LIT      = 5'd6;
    localparam logic [UPC_W-1:0] UA_LIT_DONE = 5'd7;
    localparam logic [UPC_W-1:0] UA_NEXT     = 5'd8;
    localparam logic [UPC_W-1:0] UA_TO_TOKEN = 5'd9;
    localparam logic [UPC_W-1:0] UA_MHIGH    = 5'd10;
    localparam logic [UPC_W-1:0] UA_MREAD    = 5'd11;
    localparam logic [UPC_W-1:0] UA_MCOPY    = 5'd12;
    localparam logic [UPC_W-1:0] UA_MLOOP    = 5'd13;
    localparam logic [UPC_W-1:0] UA_MDONE    = 5'd14;
    localparam logic [UPC_W-1:0] UA_TO_NEXT  = 5'd15;
    localparam logic [UPC_W-1:0] UA_HALT     = 5'd16;
    localparam logic [UPC_W-1:0] UA_ERR      = 5'd17;

    function automatic szdd_uword_t mk(input logic take, input logic emit,
                                       input szdd_op_t op, input szdd_cond_t cond,
                                       input logic [UPC_W-1:0] target);
        szdd_uword_t w;
        w.take   = take;
        w.emit   = emit;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step
    function automatic szdd_uword_t ucode(input logic [UPC_W-1:0] addr);
        szdd_uword_t w;
        case (addr)
            UA_HDR:      w = mk(1'b1, 1'b0, OP_HDR,   C_NEVER,     UA_HDR);
            UA_HDR_ERR:  w = mk(1'b0, 1'b0, OP_NONE,  C_ERR,       UA_ERR);
            UA_HDR_MORE: w = mk(1'b0, 1'b0, OP_NONE,  C_HDR_MORE,  UA_HDR);
            UA_CTRL:     w = mk(1'b1, 1'b0, OP_CTRL,  C_NEVER,     UA_CTRL);
            UA_TOKEN:    w = mk(1'b1, 1'b0, OP_TOKEN, C_NEVER,     UA_TOKEN);
            UA_KIND:     w = mk(1'b0, 1'b0, OP_NONE,  C_MATCH,     UA_MHIGH);
            UA_LIT:      w = mk(1'b0, 1'b1, OP_LIT,   C_NEVER,     UA_LIT);
            UA_LIT_DONE: w = mk(1'b0, 1'b0, OP_NONE,  C_DONE,      UA_HALT);
            UA_NEXT:     w = mk(1'b0, 1'b0, OP_NEXT,  C_LAST_FLAG, UA_CTRL);
            UA_TO_TOKEN: w = mk(1'b0, 1'b0, OP_NONE,  C_ALWAYS,    UA_TOKEN);
            UA_MHIGH:    w = mk(1'b1, 1'b0, OP_MHIGH, C_NEVER,     UA_MHIGH);
            UA_MREAD:    w = mk(1'b0, 1'b0, OP_MREAD, C_NEVER,     UA_MREAD);
            UA_MCOPY:    w = mk(1'b0, 1'b1, OP_MCOPY, C_NEVER,     UA_MCOPY);
            UA_MLOOP:    w = mk(1'b0, 1'b0, OP_NONE,  C_COPY_MORE, UA_MREAD);
            UA_MDONE:    w = mk(1'b0, 1'b0, OP_NONE,  C_DONE,      UA_HALT);
            UA_TO_NEXT:  w = mk(1'b0, 1'b0, OP_NONE,  C_ALWAYS,    UA_NEXT);
            UA_HALT:     w = mk(1'b1, 1'b0, OP_NONE,  C_ALWAYS,    UA_HALT);
            UA_ERR:      w = mk(1'b0, 1'b1, OP_ERR,   C_ALWAYS,    UA_HALT);
            default:     w = mk(1'b0, 1'b0, OP_NONE,  C_ALWAYS,    UA_HALT);
        endcase
        return w;
    endfunction

    // Expected signature bytes
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h53;
            3'd1:    v = 8'h5A;
            3'd2:    v = 8'h44;
            3'd3:    v = 8'h44;
            3'd4:    v = 8'h88;
            3'd5:    v = 8'hF0;
            3'd6:    v = 8'h27;
            3'd7:    v = 8'h33;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/szdd_lzss_decompressor.sv
// Top level of the SZDD LZSS decompressor: stream ports, datapath and output register.
// Depends on szdd_pkg, szdd_sequencer and szdd_window.
// Steps: a header byte is taken, then tested for error and for more header; a control byte is taken;
// a literal is taken, emitted and tested for the end; a match takes its low byte, then its high byte,
// then reads, copies and loop-tests per copied byte, with end and flag stepping; a stalled output adds its wait.
// Each result is registered and appears on the output in the cycle after its emit step.
// rst_n (async, low) restarts the program at the header; the window reads as spaces.
`timescale 1ns / 1ps

module szdd_lzss_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] status, [2] last_of_run
    output logic       m_axis_tlast    // end_of_file
);

    szdd_pkg::szdd_ctl_t   ctl;
    szdd_pkg::szdd_flags_t flags;

    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic        sig_bad_reg, sig_bad_next;
    logic [1:0]  err_reg, err_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] prod_reg, prod_next;
    logic [7:0]  ctl_bits_reg, ctl_bits_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [7:0]  byte_reg, byte_next;
    logic [szdd_pkg::WIN_AW-1:0] pos_reg, pos_next;
    logic [4:0]  copy_reg, copy_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_eof_reg, out_eof_next;
    logic        out_last_reg, out_last_next;

    logic        out_free;
    logic        out_load;
    logic        win_wr;
    logic        win_rd;
    logic [7:0]  win_wdata;
    logic [7:0]  win_rdata;
    logic        prod_hits_len;
    logic [31:0] owed;
    logic [4:0]  mlen;
    logic        sig_miss;

    szdd_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .flags    (flags),
        .ctl      (ctl)
    );

    szdd_window u_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (win_wr),
        .wr_data (win_wdata),
        .rd_en   (win_rd),
        .rd_addr (pos_reg),
        .rd_data (win_rdata)
    );

    assign s_axis_tready = ctl.uw.take;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = ctl.go && ctl.uw.emit;

    // Flags for the jump logic, taken from current register values
    assign flags.err       = err_reg != szdd_pkg::ST_DATA;
    assign flags.hdr_more  = hdr_idx_reg != szdd_pkg::HDR_BYTES;
    assign flags.is_match  = !ctl_bits_reg[bit_idx_reg];
    assign flags.done      = prod_reg == len_reg;
    assign flags.last_flag = bit_idx_reg == 3'd7;
    assign flags.copy_more = copy_reg != 5'd0;

    // Window access
    assign win_wr    = ctl.go && (ctl.uw.op == szdd_pkg::OP_LIT || ctl.uw.op == szdd_pkg::OP_MCOPY);
    assign win_rd    = ctl.go && (ctl.uw.op == szdd_pkg::OP_MREAD);
    assign win_wdata = (ctl.uw.op == szdd_pkg::OP_LIT) ? byte_reg : win_rdata;

    // Token arithmetic
    assign prod_hits_len = (prod_reg + 32'd1) == len_reg;
    assign owed          = len_reg - prod_reg;
    assign mlen          = {1'b0, s_axis_tdata[3:0]} + szdd_pkg::MATCH_MIN;
    assign sig_miss      = s_axis_tdata != szdd_pkg::sig_byte(hdr_idx_reg[2:0]);

    // Datapath operations of the current step
    always_comb
    begin
        hdr_idx_next  = hdr_idx_reg;
        sig_bad_next  = sig_bad_reg;
        err_next      = err_reg;
        len_next      = len_reg;
        prod_next     = prod_reg;
        ctl_bits_next = ctl_bits_reg;
        bit_idx_next  = bit_idx_reg;
        byte_next     = byte_reg;
        pos_next      = pos_reg;
        copy_next     = copy_reg;
        if (ctl.go)
        begin
            case (ctl.uw.op)
                szdd_pkg::OP_HDR:
                begin
                    hdr_idx_next = hdr_idx_reg + 4'd1;
                    if (!hdr_idx_reg[3])
                    begin
                        if (sig_miss)
                        begin
                            sig_bad_next = 1'b1;
                        end
                        if (hdr_idx_reg == szdd_pkg::HDR_LAST_SIG && (sig_bad_reg || sig_miss))
                        begin
                            err_next = szdd_pkg::ST_BAD_SIG;
                        end
                    end
                    else if (hdr_idx_reg == szdd_pkg::HDR_MODE_IDX)
                    begin
                        if (s_axis_tdata != szdd_pkg::MODE_BYTE)
                        begin
                            err_next = szdd_pkg::ST_BAD_MODE;
                        end
                    end
                    else if (hdr_idx_reg == szdd_pkg::HDR_LEN0_IDX)
                    begin
                        len_next[7:0] = s_axis_tdata;
                    end
                    else if (hdr_idx_reg == szdd_pkg::HDR_LEN1_IDX)
                    begin
                        len_next[15:8] = s_axis_tdata;
                    end
                    else if (hdr_idx_reg == szdd_pkg::HDR_LEN2_IDX)
                    begin
                        len_next[23:16] = s_axis_tdata;
                    end
                    else if (hdr_idx_reg == szdd_pkg::HDR_LEN3_IDX)
                    begin
                        len_next[31:24] = s_axis_tdata;
                        if ({s_axis_tdata, len_reg[23:0]} == 32'd0)
                        begin
                            err_next = szdd_pkg::ST_EMPTY;
                        end
                    end
                end
                szdd_pkg::OP_CTRL:
                begin
                    ctl_bits_next = s_axis_tdata;
                    bit_idx_next  = 3'd0;
                end
                szdd_pkg::OP_TOKEN:
                begin
                    byte_next = s_axis_tdata;
                end
                szdd_pkg::OP_LIT:
                begin
                    prod_next = prod_reg + 32'd1;
                end
                szdd_pkg::OP_NEXT:
                begin
                    bit_idx_next = bit_idx_reg + 3'd1;
                end
                szdd_pkg::OP_MHIGH:
                begin
                    pos_next  = {s_axis_tdata[7:4], byte_reg};
                    copy_next = (owed < {27'd0, mlen}) ? owed[4:0] : mlen;
                end
                szdd_pkg::OP_MREAD:
                begin
                    pos_next = pos_reg + 1'b1;
                end
                szdd_pkg::OP_MCOPY:
                begin
                    prod_next = prod_reg + 32'd1;
                    copy_next = copy_reg - 5'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register: load on emit, drop when taken
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_eof_next    = out_eof_reg;
        out_last_next   = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            case (ctl.uw.op)
                szdd_pkg::OP_LIT:
                begin
                    out_byte_next   = byte_reg;
                    out_status_next = szdd_pkg::ST_DATA;
                    out_eof_next    = prod_hits_len;
                    out_last_next   = 1'b1;
                end
                szdd_pkg::OP_MCOPY:
                begin
                    out_byte_next   = win_rdata;
                    out_status_next = szdd_pkg::ST_DATA;
                    out_eof_next    = prod_hits_len;
                    out_last_next   = copy_reg == 5'd1;
                end
                default:
                begin
                    out_byte_next   = 8'd0;
                    out_status_next = err_reg;
                    out_eof_next    = 1'b1;
                    out_last_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg   <= 4'd0;
            sig_bad_reg   <= 1'b0;
            err_reg       <= szdd_pkg::ST_DATA;
            len_reg       <= 32'd0;
            prod_reg      <= 32'd0;
            ctl_bits_reg  <= 8'd0;
            bit_idx_reg   <= 3'd0;
            copy_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_idx_reg   <= hdr_idx_next;
            sig_bad_reg   <= sig_bad_next;
            err_reg       <= err_next;
            len_reg       <= len_next;
            prod_reg      <= prod_next;
            ctl_bits_reg  <= ctl_bits_next;
            bit_idx_reg   <= bit_idx_next;
            copy_reg      <= copy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        pos_reg        <= pos_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_eof_reg    <= out_eof_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_last_reg, out_status_reg};
    assign m_axis_tlast  = out_eof_reg;

`ifndef ASSERT_OFF
    a_err_item_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] != szdd_pkg::ST_DATA)
            |-> (m_axis_tdata == 8'd0 && m_axis_tlast && m_axis_tuser[2]))
        else $error("error item carries data or lacks end markers");

    a_no_take_and_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && out_load))
        else $error("step both accepts an item and emits a result");

    a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.uw.op == szdd_pkg::OP_MCOPY) |-> (copy_reg != 5'd0))
        else $error("match copy step with no bytes left");

    a_prod_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_reg != 32'd0) |-> (prod_reg <= len_reg))
        else $error("produced count passed the unpacked length");
`endif

endmodule

### hw/rtl/szdd_window.sv
// 4096-byte history window: simple dual-port memory (one write, one read port) with registered read.
// Entries never written read as a space, tracked by a fill count. Uses szdd_pkg.
`timescale 1ns / 1ps

module szdd_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [szdd_pkg::WIN_AW-1:0]   rd_addr,
    output logic [7:0]                    rd_data
);

    localparam int DEPTH = 1 << szdd_pkg::WIN_AW;

    logic [7:0]                  mem [DEPTH];
    logic [7:0]                  mem_q_reg;
    logic                        hit_reg;
    logic [szdd_pkg::WIN_AW-1:0] wp_reg;
    logic [szdd_pkg::WIN_AW-1:0] wp_next;
    logic [szdd_pkg::WIN_AW:0]   fill_reg;
    logic [szdd_pkg::WIN_AW:0]   fill_next;
    logic [szdd_pkg::WIN_AW-1:0] rel;
    logic                        written;

    // Writes run in order from the start pointer, so an entry is written
    // when its distance from the start is below the fill count
    assign rel     = rd_addr - szdd_pkg::WIN_START;
    assign written = fill_reg[szdd_pkg::WIN_AW] || ({1'b0, rel} < fill_reg);

    // Advance write pointer and saturating fill count
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (wr_en)
        begin
            wp_next = wp_reg + 1'b1;
            if (!fill_reg[szdd_pkg::WIN_AW])
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= szdd_pkg::WIN_START;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            hit_reg   <= written;
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : szdd_pkg::WIN_FILL;

endmodule

### hw/rtl/szdd_sequencer.sv
// Microcode sequencer: step counter, control store lookup, stall and jump logic.
// Uses szdd_pkg for the control word, flags and program.
`timescale 1ns / 1ps

module szdd_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_free,
    input  szdd_pkg::szdd_flags_t flags,
    output szdd_pkg::szdd_ctl_t   ctl
);

    logic [szdd_pkg::UPC_W-1:0] upc_reg;
    logic [szdd_pkg::UPC_W-1:0] upc_next;
    szdd_pkg::szdd_uword_t      uw;
    logic                       go;
    logic                       jump;

    assign uw = szdd_pkg::ucode(upc_reg);

    // Hold the step while its input or output side is not ready
    assign go = !(uw.take && !in_valid) && !(uw.emit && !out_free);

    // Select the jump condition
    always_comb
    begin
        case (uw.cond)
            szdd_pkg::C_NEVER:     jump = 1'b0;
            szdd_pkg::C_ALWAYS:    jump = 1'b1;
            szdd_pkg::C_ERR:       jump = flags.err;
            szdd_pkg::C_HDR_MORE:  jump = flags.hdr_more;
            szdd_pkg::C_MATCH:     jump = flags.is_match;
            szdd_pkg::C_DONE:      jump = flags.done;
            szdd_pkg::C_LAST_FLAG: jump = flags.last_flag;
            szdd_pkg::C_COPY_MORE: jump = flags.copy_more;
            default:               jump = 1'b0;
        endcase
    end

    // Advance or branch
    always_comb
    begin
        upc_next = upc_reg;
        if (go)
        begin
            upc_next = jump ? uw.target : upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= szdd_pkg::UA_HDR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctl.uw = uw;
    assign ctl.go = go;

endmodule

### bench/szdd_stream_checker.sv
// Scoreboard for the SZDD LZSS decompressor: predicts every output item from the
// input items it sees and compares them in order. Depends on szdd_pkg.
`timescale 1ns / 1ps

module szdd_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [7:0] res_data,    // [7:0] out_byte
    input  logic [2:0] res_user,    // [1:0] status, [2] last_of_run
    input  logic       res_last,    // end_of_file
    output int         n_pending,
    output int         n_fail,
    output int         n_checked
);

    // Signature bytes, first byte in the lowest bits
    localparam logic [63:0] SZDD_MAGIC = 64'h3327_F088_4444_5A53;

    typedef enum logic [2:0] {
        P_HEADER,
        P_CONTROL,
        P_TOKEN,
        P_MATCH_HIGH,
        P_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       eof;
        logic       last;
    } out_item_t;

    out_item_t    owed_out_q[$];
    logic [7:0]   hist [0:4095];
    logic [11:0]  wr_pos;
    logic [3:0]   hdr_idx;
    logic         sig_bad;
    logic [31:0]  out_len;
    logic [31:0]  produced;
    logic [7:0]   flags;
    logic [3:0]   flag_idx;
    logic [7:0]   mlow;
    parse_phase_t phase;
    int           fail_total = 0;
    int           checked_total = 0;

    task automatic clear_decoder();
        for (int i = 0; i < 4096; i++)
            hist[i] = szdd_pkg::WIN_FILL;
        wr_pos   = szdd_pkg::WIN_START;
        hdr_idx  = '0;
        sig_bad  = 1'b0;
        out_len  = '0;
        produced = '0;
        flags    = '0;
        flag_idx = 4'd8;
        mlow     = '0;
        phase    = P_HEADER;
    endtask

    task automatic owe(input logic [7:0] d, input logic [1:0] st, input logic eof,
                       input logic last);
        out_item_t o;
        o.data   = d;
        o.status = st;
        o.eof    = eof;
        o.last   = last;
        owed_out_q = {owed_out_q, o};
    endtask

    // Write one decompressed byte into the history and expect it on the output
    task automatic emit_plain(input logic [7:0] d, input logic last);
        hist[wr_pos] = d;
        wr_pos       = wr_pos + 12'd1;
        produced     = produced + 32'd1;
        owe(d, szdd_pkg::ST_DATA, produced == out_len, last);
        if (produced == out_len)
            phase = P_DONE;
    endtask

    task automatic advance_flag();
        flag_idx = flag_idx + 4'd1;
        phase    = (flag_idx >= 4'd8) ? P_CONTROL : P_TOKEN;
    endtask

    // Run one compressed byte through the decoder
    task automatic decompress_byte(input logic [7:0] b);
        logic [3:0]  idx;
        logic [11:0] pos;
        int unsigned copy_len;
        int unsigned owed;
        case (phase)
            P_HEADER: begin
                idx     = hdr_idx;
                hdr_idx = idx + 4'd1;
                if (idx <= szdd_pkg::HDR_LAST_SIG) begin
                    if (b != SZDD_MAGIC[8 * idx +: 8])
                        sig_bad = 1'b1;
                    if (idx == szdd_pkg::HDR_LAST_SIG && sig_bad) begin
                        owe(8'h00, szdd_pkg::ST_BAD_SIG, 1'b1, 1'b1);
                        phase = P_DONE;
                    end
                end else if (idx == szdd_pkg::HDR_MODE_IDX) begin
                    if (b != szdd_pkg::MODE_BYTE) begin
                        owe(8'h00, szdd_pkg::ST_BAD_MODE, 1'b1, 1'b1);
                        phase = P_DONE;
                    end
                end else if (idx >= szdd_pkg::HDR_LEN0_IDX && idx <= szdd_pkg::HDR_LEN3_IDX) begin
                    out_len = out_len | ({24'd0, b} << (8 * (idx - szdd_pkg::HDR_LEN0_IDX)));
                    if (idx == szdd_pkg::HDR_LEN3_IDX) begin
                        if (out_len == 0) begin
                            owe(8'h00, szdd_pkg::ST_EMPTY, 1'b1, 1'b1);
                            phase = P_DONE;
                        end else begin
                            phase    = P_CONTROL;
                            flag_idx = 4'd8;
                        end
                    end
                end
            end
            P_CONTROL: begin
                flags    = b;
                flag_idx = 4'd0;
                phase    = P_TOKEN;
            end
            P_TOKEN: begin
                if (flags[flag_idx[2:0]]) begin
                    emit_plain(b, 1'b1);
                    if (phase != P_DONE)
                        advance_flag();
                end else begin
                    mlow  = b;
                    phase = P_MATCH_HIGH;
                end
            end
            P_MATCH_HIGH: begin
                pos      = {b[7:4], mlow};
                copy_len = int'(b[3:0]) + int'(szdd_pkg::MATCH_MIN);
                owed     = out_len - produced;
                if (copy_len > owed)
                    copy_len = owed;
                // Copy through the window; the source may overlap the bytes just written
                for (int k = 0; k < copy_len; k++) begin
                    emit_plain(hist[pos], k + 1 == copy_len);
                    pos = pos + 12'd1;
                end
                if (phase != P_DONE)
                    advance_flag();
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at output %0d: %s", checked_total, what);
        fail_total++;
    endtask

    task automatic check_result();
        out_item_t want;
        if (owed_out_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item data=%02h user=%0h last=%0b",
                                      res_data, res_user, res_last));
        end else begin
            want = owed_out_q.pop_front();
            if (res_data !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", res_data, want.data));
            if (res_user[1:0] !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", res_user[1:0],
                                          want.status));
            if (res_last !== want.eof)
                report_mismatch($sformatf("end_of_file %0b, want %0b", res_last, want.eof));
            if (res_user[2] !== want.last)
                report_mismatch($sformatf("last_of_run %0b, want %0b", res_user[2],
                                          want.last));
        end
        checked_total++;
    endtask

    // Predict on accepted input items, compare on accepted output items
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_decoder();
            owed_out_q.delete();
            n_pending <= 0;
        end else begin
            if (in_valid && in_ready)
                decompress_byte(in_byte);
            if (res_valid && res_ready)
                check_result();
            n_pending <= owed_out_q.size();
        end
        n_fail    <= fail_total;
        n_checked <= checked_total;
    end

endmodule

### bench/tb.sv
// Top of the SZDD LZSS decompressor bench: clock, reset, compressed-file stimulus,
// output back-pressure, watchdog and verdict. Depends on szdd_pkg,
// szdd_stream_checker and szdd_lzss_decompressor.
`timescale 1ns / 1ps

module tb;

    localparam int          FILE_ITEMS = 480;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          TAIL_WAIT  = 200;
    localparam logic [63:0] SZDD_MAGIC = 64'h3327_F088_4444_5A53;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    int n_pending;
    int n_fail;
    int n_checked;

    logic [7:0]  file_q[$];
    logic [7:0]  body_q[$];
    logic [31:0] produced = '0;
    logic [31:0] unpacked = '0;
    int          n_literals = 0;
    int          n_matches = 0;
    int          final_owed = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int unsigned cycle_no = 0;

    szdd_lzss_decompressor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    szdd_stream_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata),
        .res_user  (m_tuser),
        .res_last  (m_tlast),
        .n_pending (n_pending),
        .n_fail    (n_fail),
        .n_checked (n_checked)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [11:0] next_wr_pos();
        return szdd_pkg::WIN_START + produced[11:0];
    endfunction

    task automatic add_literal(input logic [7:0] b);
        body_q = {body_q, b};
        produced = produced + 32'd1;
        n_literals++;
    endtask

    task automatic add_match(input logic [11:0] pos, input int len);
        logic [3:0] code;
        code = 4'(len - int'(szdd_pkg::MATCH_MIN));
        body_q = {body_q, pos[7:0]};
        body_q = {body_q, {pos[11:8], code}};
        produced = produced + 32'(len);
        n_matches++;
    endtask

    // Half the matches reach back a short way, so they copy real data
    function automatic logic [11:0] pick_source();
        if ($urandom_range(0, 1) == 0)
            return next_wr_pos() - 12'($urandom_range(1, 64));
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic build_file();
        logic [7:0]  ctrl;
        logic [31:0] before_last;
        // Directed: literal extremes, match from the blank window, match across the
        // wrap, run-length style overlap and a match high in the window
        body_q = {body_q, 8'h4D};
        add_literal(8'h00);
        add_match(12'h000, 3);
        add_literal(8'hFF);
        add_literal(8'hA5);
        add_match(12'hFFF, 18);
        add_match(next_wr_pos() - 12'd1, 10);
        add_literal(8'h7F);
        add_match(12'hF00, 3);
        // Random groups of eight tokens, with all-literal and all-match groups mixed in
        while (body_q.size() < FILE_ITEMS - 32) begin
            case ($urandom_range(0, 9))
                0:       ctrl = 8'h00;
                1:       ctrl = 8'hFF;
                default: ctrl = 8'($urandom_range(0, 255));
            endcase
            body_q = {body_q, ctrl};
            for (int i = 0; i < 8; i++) begin
                if (ctrl[i])
                    add_literal(8'($urandom_range(0, 255)));
                else
                    add_match(pick_source(), $urandom_range(3, 18));
            end
        end
        // Close with a full-length match that the unpacked length may clip
        before_last = produced;
        body_q = {body_q, 8'h00};
        add_match(pick_source(), 18);
        final_owed = $urandom_range(1, 18);
        unpacked   = before_last + 32'(final_owed);
        // Trailing bytes past the end must be ignored
        repeat (5)
            body_q = {body_q, 8'($urandom_range(0, 255))};
        // Header: signature, mode, ignored byte, length little-endian
        for (int i = 0; i < 8; i++)
            file_q = {file_q, SZDD_MAGIC[8 * i +: 8]};
        file_q = {file_q, szdd_pkg::MODE_BYTE};
        file_q = {file_q, 8'($urandom_range(0, 255))};
        for (int i = 0; i < 4; i++)
            file_q = {file_q, unpacked[8 * i +: 8]};
        foreach (body_q[i])
            file_q = {file_q, body_q[i]};
    endtask

    // Present one item and hold it until taken; lower valid only when a gap or a stop follows
    task automatic send_byte(input logic [7:0] b, input bit stop, input bit calm);
        int gap;
        gap = (stop || calm) ? 0 : pick_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (stop || gap > 0)
            s_tvalid <= 1'b0;
        repeat (gap)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
    endtask

    // Output back-pressure, with calm stretches in which no new stall starts
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (((cycle_no >> 8) % 4) != 1 && $urandom_range(0, 99) < 30) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("szdd_lzss_decompressor test failed");
                $finish;
            end
        end
    end

    initial begin
        int hold_a;
        int hold_b;
        bit stop;
        build_file();
        hold_a = 14 + 27;
        hold_b = $urandom_range(80, file_q.size() - 20);
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (file_q[i]) begin
            stop = (i + 1 == file_q.size()) || (i + 1 == hold_a) || (i + 1 == hold_b);
            send_byte(file_q[i], stop, (i % 100) >= 80);
            // Hold off the sender until every owed output has come out
            if (i + 1 == hold_a || i + 1 == hold_b)
                wait_drained();
        end
        wait_drained();
        repeat (TAIL_WAIT)
            @(posedge clk);
        $display("sent %0d file bytes: %0d literals, %0d matches, length %0d",
                 items_sent, n_literals, n_matches, unpacked);
        $display("last match cut to %0d; checked %0d output bytes, %0d mismatches",
                 final_owed, n_checked, n_fail);
        if (n_fail == 0 && n_pending == 0)
            $display("szdd_lzss_decompressor test passed");
        else
            $display("szdd_lzss_decompressor test failed");
        $finish;
    end

endmodule

### szdd_lzss_decompressor.f
hw/rtl/szdd_pkg.sv
hw/rtl/szdd_window.sv
hw/rtl/szdd_sequencer.sv
hw/rtl/szdd_lzss_decompressor.sv
bench/szdd_stream_checker.sv
bench/tb.sv
